@@ rtl/core/sha1_message_digest_defines.svh @@
// Assertion macros of the SHA-1 digest checker.
// Included by the checker file; needs nothing else.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define SHA1MD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define SHA1MD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sha1md_pkg.sv @@
// Types and constants of the SHA-1 message digest block.
// No dependencies; imported by the front end, queue, core, top level and checker.
`timescale 1ns / 1ps

package sha1md_pkg;

  // Command classes that the front end sends to the core
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_BYTE_LAST,
    OP_LAST
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } core_state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_phase_t;

  // Initial hash values, element 0 is H0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] POS_BLOCK_END = 6'd63;
  localparam logic [5:0] POS_LEN_START = 6'd56;
  localparam logic [2:0] LEN_LAST_IDX  = 3'd7;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  localparam logic [6:0] RND_GROUP_1 = 7'd20;
  localparam logic [6:0] RND_GROUP_2 = 7'd40;
  localparam logic [6:0] RND_GROUP_3 = 7'd60;
  localparam logic [6:0] RND_LAST    = 7'd79;

endpackage

@@ rtl/core/sha1md_if.sv @@
// Valid/ready channel interfaces of the SHA-1 digest block: message bytes in,
// digest words out. Depend on nothing but the language.
`timescale 1ns / 1ps

interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_item;

  modport source (output valid, output data_byte, output byte_valid,
                  output last_item, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input last_item, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

@@ rtl/core/sha1md_front.sv @@
// Front end: takes input beats, drops idle items and classifies the rest.
// Uses sha1md_pkg and the input channel interface.
`timescale 1ns / 1ps

module sha1md_front (
  sha1md_in_if.sink         in_ch,
  input  sha1md_pkg::q_stat_t q_stat,
  output logic              push,
  output sha1md_pkg::q_item_t push_item
);
  import sha1md_pkg::*;

  // Accept whenever the queue has room
  assign in_ch.ready = !q_stat.full;

  // Queue only items that carry a byte or end the message
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_valid || in_ch.last_item);

  // Classify the beat
  always_comb begin
    push_item.data = in_ch.data_byte;
    unique case ({in_ch.byte_valid, in_ch.last_item})
      2'b10:   push_item.op = OP_BYTE;
      2'b11:   push_item.op = OP_BYTE_LAST;
      2'b01:   push_item.op = OP_LAST;
      default: push_item.op = OP_BYTE;
    endcase
  end

endmodule

@@ rtl/core/sha1md_fifo.sv @@
// Short command queue between the front end and the compression core.
// Uses the item and status types of sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sha1md_pkg::q_item_t push_item,
  input  logic                pop,
  output sha1md_pkg::q_item_t pop_item,
  output sha1md_pkg::q_stat_t stat
);
  import sha1md_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_item_t           mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/sha1md_core.sv @@
// Back end: packs bytes into the block, pads, runs the 80 rounds and emits
// the digest. Uses sha1md_pkg and the output channel interface.
`timescale 1ns / 1ps

module sha1md_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1md_pkg::q_stat_t q_stat,
  input  sha1md_pkg::q_item_t q_item,
  output logic                pop,
  sha1md_out_if.source        out_ch
);
  import sha1md_pkg::*;

  function automatic logic [31:0] round_f(input logic [6:0]  rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    priority if (rnd < RND_GROUP_1) f = (b & c) | (~b & d);
    else if (rnd < RND_GROUP_2)     f = b ^ c ^ d;
    else if (rnd < RND_GROUP_3)     f = (b & c) | (b & d) | (c & d);
    else                            f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    priority if (rnd < RND_GROUP_1) k = K_0;
    else if (rnd < RND_GROUP_2)     k = K_1;
    else if (rnd < RND_GROUP_3)     k = K_2;
    else                            k = K_3;
    return k;
  endfunction

  core_state_t state_r, state_nxt;
  pad_phase_t  phase_r, phase_nxt;

  logic [5:0]  pos_r;
  logic [63:0] bit_cnt_r;
  logic [31:0] h_r [5];
  logic [6:0]  rnd_r;
  logic [2:0]  len_idx_r;
  logic        pad_act_r;
  logic        final_r;
  logic [2:0]  emit_cnt_r;
  logic        out_valid_r;

  logic [23:0] acc_r;
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  logic        place;
  logic [7:0]  place_val;
  logic        take_last;
  logic        blk_full;
  logic        out_ld;
  logic        emit_done;
  logic [5:0]  pos_inc;
  logic [31:0] t_val;
  logic [31:0] w_mix;
  logic [31:0] w_new;

  assign pos_inc   = pos_r + 6'd1;
  assign blk_full  = place && (pos_r == POS_BLOCK_END);
  assign emit_done = out_ld && (emit_cnt_r == LAST_WORD_IDX);

  // Round datapath and message schedule
  assign t_val = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r
                 + round_k(rnd_r) + w_r[0];
  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end else if (take_last) begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_act_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: queue pop, byte placement, output load
  always_comb begin
    pop       = 1'b0;
    place     = 1'b0;
    place_val = '0;
    take_last = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop       = !q_stat.empty;
        place     = pop && (q_item.op == OP_BYTE || q_item.op == OP_BYTE_LAST);
        place_val = q_item.data;
        take_last = pop && (q_item.op == OP_BYTE_LAST || q_item.op == OP_LAST);
      end
      ST_PAD: begin
        place = 1'b1;
        unique case (phase_r)
          PH_MARK: place_val = PAD_MARK;
          PH_LEN:  place_val = bit_cnt_r[{~len_idx_r, 3'b000} +: 8];
          default: place_val = '0;
        endcase
      end
      ST_EMIT: begin
        out_ld = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  // Padding phase after each placed pad byte
  always_comb begin
    phase_nxt = phase_r;
    if (take_last) begin
      phase_nxt = PH_MARK;
    end else if (state_r == ST_PAD && phase_r != PH_LEN) begin
      phase_nxt = (pos_inc == POS_LEN_START) ? PH_LEN : PH_ZERO;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_MARK;
      pos_r       <= '0;
      bit_cnt_r   <= '0;
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= H_INIT[i];
      end
      rnd_r       <= '0;
      len_idx_r   <= '0;
      pad_act_r   <= 1'b0;
      final_r     <= 1'b0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;

      if (place) begin
        pos_r <= pos_inc;
      end
      if (state_r == ST_IDLE && place) begin
        bit_cnt_r <= bit_cnt_r + 64'd8;
      end

      // Start padding on the end of the message
      if (take_last) begin
        pad_act_r <= 1'b1;
        len_idx_r <= '0;
      end
      if (state_r == ST_PAD && phase_r == PH_LEN) begin
        len_idx_r <= len_idx_r + 3'd1;
        if (len_idx_r == LEN_LAST_IDX) begin
          final_r <= 1'b1;
        end
      end

      // Count rounds
      if (blk_full) begin
        rnd_r <= '0;
      end else if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 7'd1;
      end

      // Fold the working words into the hash
      if (state_r == ST_FOLD) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end

      // Hand out digest words; restore for the next message after the last
      if (out_ld) begin
        out_valid_r <= 1'b1;
        emit_cnt_r  <= emit_done ? 3'd0 : emit_cnt_r + 3'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_done) begin
        for (int i = 0; i < 5; i++) begin
          h_r[i] <= H_INIT[i];
        end
        bit_cnt_r <= '0;
        pad_act_r <= 1'b0;
        final_r   <= 1'b0;
      end
    end
  end

  // Block buffer, working words and output register
  always_ff @(posedge clk) begin
    if (place) begin
      acc_r <= {acc_r[15:0], place_val};
      if (pos_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i + 1];
        end
        w_r[15] <= {acc_r, place_val};
      end
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_new;
    end

    if (blk_full) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (state_r == ST_ROUND) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t_val;
    end

    if (out_ld) begin
      out_word_r <= h_r[emit_cnt_r];
      out_idx_r  <= emit_cnt_r;
      out_last_r <= emit_done;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = out_last_r;

endmodule

@@ rtl/core/sha1_message_digest.sv @@
// Top level of the SHA-1 message digest block: front end, command queue and
// compression core. Uses sha1md_pkg, the channel interfaces and all submodules.
`timescale 1ns / 1ps

// SHA-1 over a byte stream. Each input beat carries one message byte
// (byte_valid) and an end-of-message flag (last_item); a final beat without a
// byte is allowed, so an empty message hashes correctly, and beats with neither
// flag are dropped. Beats land in a QUEUE_DEPTH-entry queue; while idle the core
// drains one byte per cycle from it, and each full 64-byte block then runs through
// the single round unit (80 rounds, one per cycle, then a fold into the hash),
// during which no bytes are drained. On the final beat the core writes padding
// one byte per cycle (9 to 72 bytes; each block it completes goes through the
// rounds and the fold) and then presents the five digest words H0..H4 on the
// output channel, word_index 0..4 with last_word on the fifth, through an
// output register. Input is taken while the queue has room, also while digest
// words wait for the sink.

module sha1_message_digest #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  sha1md_in_if.sink    in_ch,
  sha1md_out_if.source out_ch
);
  import sha1md_pkg::*;

  q_stat_t q_stat;
  q_item_t push_item;
  q_item_t pop_item;
  logic    push;
  logic    pop;

  sha1md_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  sha1md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  sha1md_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_item (pop_item),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/core/sha1md_checker.sv @@
// Port-level checks of the digest output sequence, bound to the top level.
// Uses the assertion macros of sha1_message_digest_defines.svh.
`timescale 1ns / 1ps
`include "sha1_message_digest_defines.svh"

module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);
  import sha1md_pkg::*;

  logic out_beat;

  assign out_beat = out_valid && out_ready;

  // Hold a stalled beat
`SHA1MD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digest_word) && $stable(out_word_index) && $stable(out_last_word), "stalled digest beat changed")

  // Flag the fifth word and only it
`SHA1MD_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, out_last_word == (out_word_index == LAST_WORD_IDX), "last_word does not match word_index")

  // Step the word index by one within a digest
`SHA1MD_ASSERT_NXT(a_index_step, clk, rst_n, out_beat && !out_last_word, !out_valid || out_word_index == $past(out_word_index) + 3'd1, "digest word skipped or repeated")

  // Start the next digest at word zero
`SHA1MD_ASSERT_NXT(a_index_wrap, clk, rst_n, out_beat && out_last_word, !out_valid || out_word_index == 3'd0, "digest does not start at word zero")

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last_word   (out_ch.last_word)
);
